FILE: hdl/vsa_pkg.sv
// vsa_pkg: shared constants for the voice slot allocator.
// Action, status and category codes, field widths and packing sizes.
// No dependencies.
package vsa_pkg;

    localparam int DEF_VOICE_SLOTS = 32;

    localparam int ACT_W    = 3;
    localparam int CAT_W    = 4;
    localparam int GAIN_W   = 16;
    localparam int HANDLE_W = 32;
    localparam int GEN_W    = 16;
    localparam int STAT_W   = 3;
    localparam int CNT_O_W  = 6;
    localparam int VOL_W    = 7;
    localparam int NUM_VOL  = 8;
    localparam int VIDX_W   = 3;

    // stream word sizes, padded to whole bytes
    localparam int IN_W  = 56;
    localparam int OUT_W = 48;

    localparam logic [ACT_W-1:0] ACT_REQUEST  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_KILL     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_VALIDATE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FINISHED = 3'd3;
    localparam logic [ACT_W-1:0] ACT_KILL_ALL = 3'd4;
    localparam logic [ACT_W-1:0] ACT_KILL_MUS = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SUSPEND  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_SUSPENDED = 3'd1;
    localparam logic [STAT_W-1:0] ST_MUTED     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SLOT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

    localparam logic [CAT_W-1:0] CAT_MASTER  = 4'd0;
    localparam logic [CAT_W-1:0] CAT_MUSIC   = 4'd1;
    localparam logic [CAT_W-1:0] CAT_AMBIENT = 4'd8;

    localparam logic [VOL_W-1:0] VOL_FULL  = 7'd100;
    // 10*v*g <= 256 holds exactly when v*g <= 25
    localparam logic [VOL_W+GAIN_W-1:0] MUTE_LIMIT = 23'd25;

endpackage

FILE: hdl/voice_slot_allocator_with_handles.sv
// voice_slot_allocator_with_handles: voice slot allocator with generation handles.
// Depends on vsa_pkg.
//
// Channel   | Direction | Signals                          | Word
// s (items) | in        | i_s_tvalid o_s_tready i_s_tdata  | action, category, gain, handle, flag
// m (result)| out       | o_m_tvalid i_m_tready o_m_tdata  | new_handle, status, valid, count, music
// cfg       | in        | i_cfg_valid o_cfg_ready          | i_cfg_index, i_cfg_data
//
// Input stage, then result register; one word per cycle while results are taken.
// The generation memory is read at accept, so the slot search runs on the busy bits that the
// word ahead leaves; a bypass covers a write to the same slot in that cycle.
// Reset clears busy bits, generation valid bits, suspend and sets volumes to 100; no sweep.
// A stalled result holds; the input stage waits and takes no word until it can advance.
module voice_slot_allocator_with_handles
    import vsa_pkg::*;
#(
    parameter int VOICE_SLOTS = DEF_VOICE_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // [2:0] action, [6:3] category, [22:7] gain, [54:23] handle, [55] suspend_flag
    input  logic [IN_W-1:0]    i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // [31:0] new_handle, [34:32] status, [35] handle_valid, [41:36] active_count,
    // [42] music_playing, [47:43] zero
    output logic [OUT_W-1:0]   o_m_tdata,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [VIDX_W-1:0]  i_cfg_index,
    input  logic [VOL_W-1:0]   i_cfg_data
);

    localparam int SLOT_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(VOICE_SLOTS + 1);

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_pick;

    // lowest free slot that the category may use
    function automatic t_pick first_free(input logic [VOICE_SLOTS-1:0] busy,
                                         input logic [CAT_W-1:0] cat);
        t_pick p;
        logic  ok;
        p = '0;
        for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
            if (cat == CAT_MUSIC) begin
                ok = (i == 0);
            end else if (cat == CAT_AMBIENT) begin
                ok = 1'b1;
            end else begin
                ok = (i != 0);
            end
            if (ok && !busy[i]) begin
                p.hit = 1'b1;
                p.idx = SLOT_W'(i);
            end
        end
        return p;
    endfunction

    // configuration
    logic [VOL_W-1:0] r_vol [NUM_VOL];

    // slot state
    logic [VOICE_SLOTS-1:0] r_busy, n_busy;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_mus0, n_mus0;
    logic                 r_susp, n_susp;
    logic [VOICE_SLOTS-1:0] r_gvld;
    logic [GEN_W-1:0]     r_gen_mem [VOICE_SLOTS];

    // input stage
    logic                 r_v1;
    logic [ACT_W-1:0]     r_action;
    logic [CAT_W-1:0]     r_cat;
    logic [GAIN_W-1:0]    r_gain;
    logic [HANDLE_W-1:0]  r_handle;
    logic                 r_flag;
    t_pick                r_pick;
    logic [GEN_W-1:0]     r_mem_q;
    logic                 r_gvld_q;
    logic                 r_byp;
    logic [GEN_W-1:0]     r_byp_gen;

    // result register
    logic                 r_mv;
    logic [OUT_W-1:0]     r_mdata;

    logic                 s1_fire, accept;
    logic [ACT_W-1:0]     a_action;
    logic [CAT_W-1:0]     a_cat_raw, a_cat;
    logic [HANDLE_W-1:0]  a_handle;
    t_pick                a_pick;
    logic [SLOT_W-1:0]    rd_addr;

    logic                 mem_we, wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    logic [GEN_W-1:0]     gen_cur, gen_new;

    logic [VOL_W-1:0]     vol;
    logic [VOL_W+GAIN_W-1:0] loud;
    logic                 muted;
    logic [SLOT_W-1:0]    hidx;
    logic                 h_range, h_live, music_on;

    logic [HANDLE_W-1:0]  res_handle;
    logic [STAT_W-1:0]    res_status;
    logic                 res_valid;

    assign o_cfg_ready = 1'b1;
    assign s1_fire     = r_v1 && (!r_mv || i_m_tready);
    assign o_s_tready  = !r_v1 || s1_fire;
    assign accept      = i_s_tvalid && o_s_tready;

    assign a_action  = i_s_tdata[2:0];
    assign a_cat_raw = i_s_tdata[6:3];
    assign a_handle  = i_s_tdata[54:23];
    assign a_cat     = (a_cat_raw > CAT_AMBIENT) ? CAT_MASTER : a_cat_raw;
    // search on the busy bits this word will see once the word ahead commits
    assign a_pick    = first_free(n_busy, a_cat);
    assign rd_addr   = (a_action == ACT_REQUEST) ? a_pick.idx : a_handle[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOL; i++) begin
                r_vol[i] <= VOL_FULL;
            end
        end else if (i_cfg_valid) begin
            r_vol[i_cfg_index] <= i_cfg_data;
        end
    end

    // generation memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_gen_mem[wr_addr] <= gen_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_q <= r_gen_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvld <= '0;
        end else if (wr_en) begin
            r_gvld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (accept) begin
            r_v1 <= 1'b1;
        end else if (s1_fire) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= a_action;
            r_cat     <= a_cat;
            r_gain    <= i_s_tdata[22:7];
            r_handle  <= a_handle;
            r_flag    <= i_s_tdata[55];
            r_pick    <= a_pick;
            r_gvld_q  <= r_gvld[rd_addr];
            r_byp     <= wr_en && (wr_addr == rd_addr);
            r_byp_gen <= gen_new;
        end
    end

    // untouched generation reads as zero
    assign gen_cur = r_byp ? r_byp_gen : (r_gvld_q ? r_mem_q : '0);
    assign gen_new = gen_cur + 16'd1;
    assign wr_addr = r_pick.idx;
    assign wr_en   = mem_we && s1_fire;

    always_comb begin
        if (r_cat == CAT_MASTER) begin
            vol = VOL_FULL;
        end else begin
            vol = r_vol[VIDX_W'(r_cat - 4'd1)];
        end
    end

    assign loud     = vol * r_gain;
    assign muted    = loud <= MUTE_LIMIT;
    assign hidx     = r_handle[SLOT_W-1:0];
    assign h_range  = r_handle[15:0] < 16'(VOICE_SLOTS);
    assign h_live   = (r_handle != '0) && h_range && r_busy[hidx]
                      && (gen_cur == r_handle[31:16]);
    assign music_on = r_busy[0] && r_mus0;

    always_comb begin
        n_busy     = r_busy;
        n_cnt      = r_cnt;
        n_mus0     = r_mus0;
        n_susp     = r_susp;
        mem_we     = 1'b0;
        res_handle = '0;
        res_status = ST_OK;
        res_valid  = 1'b0;
        if (r_v1) begin
            case (r_action)
                ACT_REQUEST: begin
                    if (r_susp) begin
                        res_status = ST_SUSPENDED;
                    end else if (muted) begin
                        res_status = ST_MUTED;
                    end else if (!r_pick.hit) begin
                        res_status = ST_NO_SLOT;
                    end else begin
                        n_busy[r_pick.idx] = 1'b1;
                        n_cnt              = CNT_W'(r_cnt + 1'b1);
                        if (r_pick.idx == '0) begin
                            n_mus0 = (r_cat == CAT_MUSIC);
                        end
                        mem_we     = 1'b1;
                        res_handle = {gen_new, 16'(r_pick.idx)};
                    end
                end
                ACT_KILL: begin
                    if (h_live) begin
                        n_busy[hidx] = 1'b0;
                        n_cnt        = CNT_W'(r_cnt - 1'b1);
                        res_valid    = 1'b1;
                    end else begin
                        res_status = ST_INVALID;
                    end
                end
                ACT_VALIDATE: begin
                    if (h_live) begin
                        res_valid = 1'b1;
                    end else begin
                        res_status = ST_INVALID;
                    end
                end
                ACT_FINISHED: begin
                    if (h_range) begin
                        n_busy[hidx] = 1'b0;
                        if (r_busy[hidx]) begin
                            n_cnt = CNT_W'(r_cnt - 1'b1);
                        end
                    end else begin
                        res_status = ST_INVALID;
                    end
                end
                ACT_KILL_ALL: begin
                    n_busy = '0;
                    n_cnt  = '0;
                end
                ACT_KILL_MUS: begin
                    if (music_on) begin
                        n_busy[0] = 1'b0;
                        n_cnt     = CNT_W'(r_cnt - 1'b1);
                    end
                end
                ACT_SUSPEND: begin
                    n_susp = r_flag;
                end
                default: begin
                end
            endcase
        end
    end

    // commit slot state only when the stage advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_cnt  <= '0;
            r_mus0 <= 1'b0;
            r_susp <= 1'b0;
        end else if (s1_fire) begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_mus0 <= n_mus0;
            r_susp <= n_susp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (s1_fire) begin
            r_mv <= 1'b1;
        end else if (i_m_tready) begin
            r_mv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_mdata <= {5'd0, n_busy[0] && n_mus0, CNT_O_W'(n_cnt), res_valid,
                        res_status, res_handle};
        end
    end

    assign o_m_tvalid = r_mv;
    assign o_m_tdata  = r_mdata;

endmodule

FILE: hdl/vsa_chk.sv
// vsa_chk: port-level checks for the voice slot allocator, bound to the top level.
// Depends on vsa_pkg and voice_slot_allocator_with_handles.
module vsa_chk
    import vsa_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_m_tready,
    input logic             o_m_tvalid,
    input logic [OUT_W-1:0] o_m_tdata
);

    logic [STAT_W-1:0] w_status;
    assign w_status = o_m_tdata[34:32];

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_status == ST_OK) || (w_status == ST_SUSPENDED)
                       || (w_status == ST_MUTED) || (w_status == ST_NO_SLOT)
                       || (w_status == ST_INVALID))
        else $error("status code out of range");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[31:0] != '0) |-> (w_status == ST_OK) && !o_m_tdata[35])
        else $error("granted handle with bad status or valid flag");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[35] |-> (w_status == ST_OK))
        else $error("live handle reported with error status");

endmodule

bind voice_slot_allocator_with_handles vsa_chk u_vsa_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata)
);

FILE: verif/voice_slot_allocator_with_handles_tb.sv
`timescale 1ns / 1ps
// voice_slot_allocator_with_handles_tb: self-checking bench for the voice slot allocator.
// Keeps its own slot, generation and volume model and checks every result word against it.
// Depends on vsa_pkg and the allocator RTL.
module voice_slot_allocator_with_handles_tb;
    import vsa_pkg::*;

    localparam int VOICE_SLOTS  = DEF_VOICE_SLOTS;
    localparam int HOLD_CYCLES  = 150;
    localparam int FLUSH_CYCLES = 16;
    localparam int MAX_REPORTS  = 40;
    localparam int MUSIC_LAPS   = 12;

    localparam logic [ACT_W-1:0] ACT_UNUSED  = 3'd7;
    localparam logic [CAT_W-1:0] CAT_WEATHER = 4'd2;
    localparam logic [CAT_W-1:0] CAT_HOSTILE = 4'd3;
    localparam logic [CAT_W-1:0] CAT_LAST    = 4'd8;
    localparam logic [CAT_W-1:0] CAT_STRAY   = 4'd15;

    // input word, lowest bits first: action, category, gain, handle, flag
    typedef struct packed {
        logic                flag;
        logic [HANDLE_W-1:0] handle;
        logic [GAIN_W-1:0]   gain;
        logic [CAT_W-1:0]    category;
        logic [ACT_W-1:0]    action;
    } t_voice_req;

    // result word, lowest bits first: new_handle, status, handle_valid, count, music, pad
    typedef struct packed {
        logic [4:0]          pad;
        logic                music_playing;
        logic [CNT_O_W-1:0]  active_count;
        logic                handle_valid;
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] new_handle;
    } t_voice_res;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata   = '0;
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [VIDX_W-1:0] i_cfg_index = '0;
    logic [VOL_W-1:0]  i_cfg_data  = '0;

    // model of the allocator
    logic              slot_busy [VOICE_SLOTS];
    logic [GEN_W-1:0]  slot_gen  [VOICE_SLOTS];
    logic [CAT_W-1:0]  slot_cat  [VOICE_SLOTS];
    logic              is_suspended;
    logic [VOL_W-1:0]  cat_vol   [NUM_VOL];

    t_voice_req pending_words [$];
    t_voice_res due_results   [$];

    logic in_taken    = 1'b0;
    bit   no_gaps     = 1'b0;
    int   send_gap    = 0;
    int   send_run    = 0;
    int   stall_left  = 0;
    int   recv_run    = 0;
    int   hold_asked  = 0;
    int   hold_served = 0;
    int   hold_left   = 0;
    int   mismatches  = 0;

    always #10 i_clk = ~i_clk;

    voice_slot_allocator_with_handles #(
        .VOICE_SLOTS(VOICE_SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("ERROR at %0t ns: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic live_handle(input logic [HANDLE_W-1:0] h);
        logic [15:0] s;
        s = h[15:0];
        if (h == '0 || s >= VOICE_SLOTS)
            return 1'b0;
        return slot_busy[s] && slot_gen[s] == h[HANDLE_W-1:16];
    endfunction

    // Advance the model by one word and return the result it must produce.
    function automatic t_voice_res step_voices(input t_voice_req w);
        t_voice_res       r;
        logic [CAT_W-1:0] c;
        int               v;
        int               lo;
        int               hi;
        int               found;
        int               n;
        r = '0;
        r.status = ST_OK;
        case (w.action)
            ACT_REQUEST: begin
                c  = (w.category > CAT_LAST) ? CAT_MASTER : w.category;
                v  = (c == CAT_MASTER) ? int'(VOL_FULL) : int'(cat_vol[c - 1]);
                lo = (c == CAT_MUSIC || c == CAT_AMBIENT) ? 0 : 1;
                hi = (c == CAT_MUSIC) ? 1 : VOICE_SLOTS;
                found = VOICE_SLOTS;
                for (int i = lo; i < hi; i++)
                    if (!slot_busy[i] && found == VOICE_SLOTS)
                        found = i;
                if (is_suspended) begin
                    r.status = ST_SUSPENDED;
                end else if (10 * v * int'(w.gain) <= 256) begin
                    r.status = ST_MUTED;
                end else if (found == VOICE_SLOTS) begin
                    r.status = ST_NO_SLOT;
                end else begin
                    slot_busy[found] = 1'b1;
                    slot_cat[found]  = c;
                    slot_gen[found]  = slot_gen[found] + 1'b1;
                    r.new_handle     = {slot_gen[found], 16'(found)};
                end
            end
            ACT_KILL: begin
                if (live_handle(w.handle)) begin
                    slot_busy[w.handle[15:0]] = 1'b0;
                    r.handle_valid = 1'b1;
                end else begin
                    r.status = ST_INVALID;
                end
            end
            ACT_VALIDATE: begin
                if (live_handle(w.handle))
                    r.handle_valid = 1'b1;
                else
                    r.status = ST_INVALID;
            end
            ACT_FINISHED: begin
                if (w.handle[15:0] < VOICE_SLOTS)
                    slot_busy[w.handle[15:0]] = 1'b0;
                else
                    r.status = ST_INVALID;
            end
            ACT_KILL_ALL: begin
                for (int i = 0; i < VOICE_SLOTS; i++)
                    slot_busy[i] = 1'b0;
            end
            ACT_KILL_MUS: begin
                if (slot_busy[0] && slot_cat[0] == CAT_MUSIC)
                    slot_busy[0] = 1'b0;
            end
            ACT_SUSPEND: begin
                is_suspended = w.flag;
            end
            default: begin
            end
        endcase
        n = 0;
        for (int i = 0; i < VOICE_SLOTS; i++)
            n += slot_busy[i];
        r.active_count  = CNT_O_W'(n);
        r.music_playing = slot_busy[0] && slot_cat[0] == CAT_MUSIC;
        return r;
    endfunction

    function automatic t_voice_req make_word(input logic [ACT_W-1:0] act,
                                             input logic [CAT_W-1:0] cat,
                                             input logic [GAIN_W-1:0] g,
                                             input logic [HANDLE_W-1:0] h,
                                             input logic f);
        t_voice_req w;
        w.action   = act;
        w.category = cat;
        w.gain     = g;
        w.handle   = h;
        w.flag     = f;
        return w;
    endfunction

    // Mostly a live handle taken from the model, sometimes an aged or a junk one.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int                  live [$];
        int                  s;
        logic [HANDLE_W-1:0] h;
        for (int i = 0; i < VOICE_SLOTS; i++)
            if (slot_busy[i])
                live.push_back(i);
        h = $urandom();
        if (live.size() > 0 && $urandom_range(99) >= 15) begin
            s = live[$urandom_range(live.size() - 1)];
            h = {slot_gen[s], 16'(s)};
            if ($urandom_range(99) < 8)
                h[HANDLE_W-1:16] = slot_gen[s] - 1'b1;
        end else if ($urandom_range(1) == 1) begin
            h[15:0] = 16'($urandom_range(VOICE_SLOTS - 1));
        end
        return h;
    endfunction

    function automatic t_voice_req draw_item(input int req_pct);
        t_voice_req  w;
        logic [63:0] raw;
        int          r;
        raw = {$urandom(), $urandom()};
        w   = raw[IN_W-1:0];
        r   = $urandom_range(99);
        if (r < req_pct) begin
            w.action = ACT_REQUEST;
            if ($urandom_range(99) < 85)
                w.category = CAT_W'($urandom_range(CAT_LAST));
            if ($urandom_range(99) < 12)
                w.gain = GAIN_W'($urandom_range(30));
        end else begin
            r = $urandom_range(99);
            if (r < 25) begin
                w.action = ACT_KILL;
                w.handle = pick_handle();
            end else if (r < 50) begin
                w.action = ACT_VALIDATE;
                w.handle = pick_handle();
            end else if (r < 65) begin
                w.action = ACT_FINISHED;
                w.handle = pick_handle();
                w.handle[HANDLE_W-1:16] = GEN_W'($urandom());
            end else if (r < 70) begin
                w.action = ACT_KILL_ALL;
            end else if (r < 78) begin
                w.action = ACT_KILL_MUS;
            end else if (r < 88) begin
                w.action = ACT_SUSPEND;
                w.flag   = ($urandom_range(99) < 35);
            end else if (r < 91) begin
                w.action = ACT_UNUSED;
            end
            // otherwise keep the raw word: any action, any fields
        end
        return w;
    endfunction

    // Keep the backlog short so handles are drawn from a nearly current model.
    task automatic queue_item(input t_voice_req w);
        while (pending_words.size() >= 4)
            @(negedge i_clk);
        pending_words.push_back(w);
    endtask

    // sample at the rising edge, where the offered word and the queues have settled
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || i_s_tvalid || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_volume(input int idx, input int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= VIDX_W'(idx);
        i_cfg_data  <= VOL_W'(val);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_volumes(input int lo, input int hi);
        for (int i = 0; i < NUM_VOL; i++)
            write_volume(i, $urandom_range(hi, lo));
    endtask

    task automatic run_mix(input int count, input int req_pct, input bit with_hold);
        for (int n = 0; n < count; n++) begin
            // stall the result side while words keep coming
            if (with_hold && n == 20)
                hold_asked++;
            queue_item(draw_item(req_pct));
        end
    endtask

    // sender: offer words from the queue, with random gaps
    always @(negedge i_clk) begin : drive_items
        int r;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !in_taken) begin
            // hold the offered word until it is taken
        end else if (send_gap > 0) begin
            i_s_tvalid <= 1'b0;
            send_gap--;
        end else if (pending_words.size() > 0) begin
            i_s_tdata  <= pending_words.pop_front();
            i_s_tvalid <= 1'b1;
            r = $urandom_range(99);
            if (send_run > 0)
                send_run--;
            else if (!no_gaps && r < 3)
                send_run = 30;
            else if (!no_gaps && r >= 55)
                send_gap = (r < 85) ? $urandom_range(3, 1) :
                           (r < 97) ? $urandom_range(10, 4) : $urandom_range(60, 20);
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin : drain_results
        int r;
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (no_gaps) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            r = $urandom_range(99);
            if (recv_run > 0)
                recv_run--;
            else if (r < 3)
                recv_run = 40;
            else if (r >= 70)
                stall_left = (r < 92) ? $urandom_range(3, 1) :
                             (r < 98) ? $urandom_range(12, 4) : $urandom_range(50, 20);
        end
    end

    // predict on every accepted word, check every accepted result word
    always @(posedge i_clk) begin : watch_results
        t_voice_res got;
        t_voice_res want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_s_tvalid && o_s_tready;
            if (i_cfg_valid && o_cfg_ready)
                cat_vol[i_cfg_index] = i_cfg_data;
            if (i_s_tvalid && o_s_tready)
                due_results.push_back(step_voices(i_s_tdata));
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                if (due_results.size() == 0) begin
                    flag_mismatch("result word with nothing pending", got.new_handle, '0);
                end else begin
                    want = due_results.pop_front();
                    if (got.new_handle !== want.new_handle)
                        flag_mismatch("new_handle", got.new_handle, want.new_handle);
                    if (got.status !== want.status)
                        flag_mismatch("status", got.status, want.status);
                    if (got.handle_valid !== want.handle_valid)
                        flag_mismatch("handle_valid", got.handle_valid, want.handle_valid);
                    if (got.active_count !== want.active_count)
                        flag_mismatch("active_count", got.active_count, want.active_count);
                    if (got.music_playing !== want.music_playing)
                        flag_mismatch("music_playing", got.music_playing, want.music_playing);
                end
            end
        end
    end

    initial begin : run_phases
        logic [VOL_W-1:0] dir_vol [NUM_VOL];
        for (int i = 0; i < VOICE_SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_gen[i]  = '0;
            slot_cat[i]  = CAT_MASTER;
        end
        for (int i = 0; i < NUM_VOL; i++) begin
            cat_vol[i] = VOL_FULL;
            dir_vol[i] = VOL_FULL;
        end
        is_suspended = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_vol[CAT_WEATHER - 1] = '0;
        dir_vol[CAT_HOSTILE - 1] = 7'd1;
        for (int i = 0; i < NUM_VOL; i++)
            write_volume(i, dir_vol[i]);

        // directed: mute edges, slot rules, handle checks, suspend
        queue_item(make_word(ACT_VALIDATE, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_MASTER, 16'd0, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_MASTER, 16'd1, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_WEATHER, '1, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_HOSTILE, 16'd25, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_HOSTILE, 16'd26, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_MUSIC, '1, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_MUSIC, '1, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_AMBIENT, '1, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_STRAY, '1, '0, 1'b0));
        queue_item(make_word(ACT_VALIDATE, CAT_MASTER, '0, {16'd1, 16'd1}, 1'b0));
        queue_item(make_word(ACT_VALIDATE, CAT_MASTER, '0, {16'd2, 16'd1}, 1'b0));
        queue_item(make_word(ACT_VALIDATE, CAT_MASTER, '0, {16'd1, 16'd32}, 1'b0));
        queue_item(make_word(ACT_KILL, CAT_MASTER, '0, {16'd1, 16'd2}, 1'b0));
        queue_item(make_word(ACT_KILL, CAT_MASTER, '0, {16'd1, 16'd2}, 1'b0));
        queue_item(make_word(ACT_FINISHED, CAT_MASTER, '0, {16'hABCD, 16'd3}, 1'b0));
        queue_item(make_word(ACT_FINISHED, CAT_MASTER, '0, {16'd0, 16'hFFFF}, 1'b0));
        queue_item(make_word(ACT_KILL_MUS, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_KILL_MUS, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_SUSPEND, CAT_MASTER, '0, '0, 1'b1));
        queue_item(make_word(ACT_REQUEST, CAT_MASTER, '1, '0, 1'b0));
        queue_item(make_word(ACT_VALIDATE, CAT_MASTER, '0, {16'd1, 16'd1}, 1'b0));
        queue_item(make_word(ACT_SUSPEND, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_UNUSED, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_KILL_ALL, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_AMBIENT, '1, '0, 1'b0));
        queue_item(make_word(ACT_KILL_MUS, CAT_MASTER, '0, '0, 1'b0));
        wait_idle();

        // grant and release slot 0 back to back at full rate
        set_volumes(VOL_FULL, VOL_FULL);
        queue_item(make_word(ACT_KILL_ALL, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_SUSPEND, CAT_MASTER, '0, '0, 1'b0));
        wait_idle();
        no_gaps = 1'b1;
        for (int n = 0; n < MUSIC_LAPS; n++) begin
            queue_item(make_word(ACT_REQUEST, CAT_MUSIC, '1, '0, 1'b0));
            if (n < MUSIC_LAPS - 1)
                queue_item(make_word(ACT_FINISHED, CAT_MASTER, '0, '0, 1'b0));
        end
        // handle zero is never live
        queue_item(make_word(ACT_VALIDATE, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_KILL_MUS, CAT_MASTER, '0, '0, 1'b0));
        queue_item(make_word(ACT_REQUEST, CAT_MUSIC, '1, '0, 1'b0));
        wait_idle();
        no_gaps = 1'b0;

        run_mix(100, 50, 1'b1);
        wait_idle();
        set_volumes(0, 0);
        run_mix(100, 60, 1'b0);
        wait_idle();
        set_volumes(0, VOL_FULL);
        run_mix(100, 85, 1'b1);
        wait_idle();
        set_volumes(1, 1);
        run_mix(100, 50, 1'b0);
        wait_idle();
        set_volumes(0, VOL_FULL);
        run_mix(100, 45, 1'b0);
        wait_idle();

        repeat (FLUSH_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("voice_slot_allocator_with_handles: match");
        else
            $display("voice_slot_allocator_with_handles: mismatch");
        $finish;
    end

    initial begin : watchdog
        #16_000_000;
        $display("voice_slot_allocator_with_handles: mismatch");
        $finish;
    end

endmodule
